### hdl/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge out of reset.
`define DOBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold out of reset.
`define DOBD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hdl/dobd_pkg.sv
package dobd_pkg;

  // Width of the day counter that is honored
  localparam int COUNT_WIDTH = 16;
  localparam int CNT_IN_W    = 16;
  localparam int REM_W       = (COUNT_WIDTH < CNT_IN_W) ? COUNT_WIDTH : CNT_IN_W;

  localparam logic [13:0] YEAR_MAX = 14'd9999;
  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_DEC = 4'd12;

  // Reciprocal of 400 for year / 400 on 14-bit years
  localparam logic [12:0] RECIP_400 = 13'd5243;
  localparam int          RECIP_SH  = 21;
  localparam logic [8:0]  R400_LAST = 9'd399;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture an input word
    logic mul;   // year times reciprocal
    logic rmod;  // year mod 400
    logic chk;   // validate start date
    logic step;  // one month per cycle
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic finish;  // count used up or error raised
  } sts_t;

  // Leap year from year mod 400 (low two bits equal those of the year)
  function automatic logic is_leap(input logic [8:0] r400);
    logic res;
    res = (r400[1:0] == 2'd0) && (r400 != 9'd100) && (r400 != 9'd200) &&
          (r400 != 9'd300);
    return res;
  endfunction

  // Month length, zero for month codes outside 1 to 12
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

### hdl/date_offset_by_days_top.sv
// Gregorian date offset by a day count.
// Input stream: one word per request carrying start day, month, year and a
// day count in tdata, and the direction (0 add, 1 subtract) in tuser.
// Output stream: one word per request with the resulting day, month and year
// in tdata and the error flag in tuser. On error the start date comes back.
// Sequence: after the accepting edge come the setup steps (reciprocal
// multiply, year mod 400, date check), then the loop steps (a month
// boundary crossed or the final partial month), then a step that sees the
// loop done and registers m_axis_tvalid high.
// One request is worked on at a time; s_axis_tready is high only while idle,
// so a new word is taken in the cycle after the result is taken at the earliest.
// When the receiver stalls, the result stays on the output until taken and
// no new request is accepted. Reset returns the block to idle with
// m_axis_tvalid low; s_axis_tready is low during reset and rises in the cycle
// after it is released.
`include "assert_macros.svh"

module date_offset_by_days_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] start_day, [8:5] start_month, [22:9] start_year,
  // [38:23] day_count, [39] zero
  input  logic [39:0] s_axis_tdata,
  // [0] operation
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] result_day, [8:5] result_month, [22:9] result_year, [23] zero
  output logic [23:0] m_axis_tdata,
  // [0] error_flag
  output logic [0:0]  m_axis_tuser
);

  dobd_pkg::cmd_t cmd;
  dobd_pkg::sts_t sts;
  logic [4:0]     result_day;
  logic [3:0]     result_month;
  logic [13:0]    result_year;
  logic           error_flag;
  logic           in_fire;
  logic           month_ok;

  dobd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .cmd_o      (cmd)
  );

  dobd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .start_day_i    (s_axis_tdata[4:0]),
    .start_month_i  (s_axis_tdata[8:5]),
    .start_year_i   (s_axis_tdata[22:9]),
    .day_count_i    (s_axis_tdata[38:23]),
    .operation_i    (s_axis_tuser[0]),
    .sts_o          (sts),
    .result_day_o   (result_day),
    .result_month_o (result_month),
    .result_year_o  (result_year),
    .error_flag_o   (error_flag)
  );

  assign m_axis_tdata = {1'b0, result_year, result_month, result_day};
  assign m_axis_tuser = error_flag;

  // Check helpers
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign month_ok = (result_month >= dobd_pkg::MONTH_JAN) &&
                    (result_month <= dobd_pkg::MONTH_DEC);

  // Checks
  `DOBD_NEVER(a_one_side, s_axis_tready && m_axis_tvalid, "ready while result pending")
  `DOBD_ASSERT(a_busy_after_accept, in_fire |=> !s_axis_tready, "ready after accept")
  `DOBD_ASSERT(a_month_range, (m_axis_tvalid && !error_flag) |-> month_ok, "bad result month")

endmodule

### hdl/dobd_ctrl.sv
module dobd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  input  logic           m_tready_i,
  input  dobd_pkg::sts_t sts_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  output dobd_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_CHK,
    ST_STEP,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   s_tready_q;
  logic   m_tvalid_q;
  logic   accept;

  assign accept = s_tvalid_i && s_tready_q;

  // Sequencer: load, multiply and mod setup, check, month steps, hand off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      s_tready_q <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q    <= ST_MUL;
            s_tready_q <= 1'b0;
          end else begin
            s_tready_q <= 1'b1;
          end
        end
        ST_MUL: state_q <= ST_MOD;
        ST_MOD: state_q <= ST_CHK;
        ST_CHK: state_q <= ST_STEP;
        ST_STEP: begin
          if (sts_i.finish) begin
            state_q    <= ST_OUT;
            m_tvalid_q <= 1'b1;
          end
        end
        ST_OUT: begin
          if (m_tready_i) begin
            state_q    <= ST_IDLE;
            m_tvalid_q <= 1'b0;
            s_tready_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd_o      = '0;
    cmd_o.load = accept;
    cmd_o.mul  = (state_q == ST_MUL);
    cmd_o.rmod = (state_q == ST_MOD);
    cmd_o.chk  = (state_q == ST_CHK);
    cmd_o.step = (state_q == ST_STEP);
  end

  assign s_tready_o = s_tready_q;
  assign m_tvalid_o = m_tvalid_q;

endmodule

### hdl/dobd_dp.sv
module dobd_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dobd_pkg::cmd_t             cmd_i,
  input  logic [4:0]                 start_day_i,
  input  logic [3:0]                 start_month_i,
  input  logic [13:0]                start_year_i,
  input  logic [dobd_pkg::CNT_IN_W-1:0] day_count_i,
  input  logic                       operation_i,
  output dobd_pkg::sts_t             sts_o,
  output logic [4:0]                 result_day_o,
  output logic [3:0]                 result_month_o,
  output logic [13:0]                result_year_o,
  output logic                       error_flag_o
);

  logic [4:0]  d_q, d_d, d0_q;
  logic [3:0]  m_q, m_d, m0_q;
  logic [13:0] y_q, y_d, y0_q;
  logic [8:0]  r400_q, r400_d;
  logic [dobd_pkg::REM_W-1:0] rem_q, rem_d;
  logic        sub_q;
  logic        err_q, err_d;
  logic [26:0] prod_q;

  logic        leap;
  logic [4:0]  dim;
  logic [4:0]  left;
  logic [4:0]  prev_len;
  logic [5:0]  quot;
  logic [13:0] r400_full;
  logic        finish;

  assign leap      = dobd_pkg::is_leap(r400_q);
  assign dim       = dobd_pkg::days_in(m_q, leap);
  assign left      = dim - d_q;
  assign prev_len  = dobd_pkg::days_in(m_q - 4'd1, leap);
  assign quot      = prod_q[dobd_pkg::RECIP_SH +: 6];
  assign r400_full = y_q - (14'(quot) * 14'd400);
  assign finish    = (rem_q == '0) || err_q;

  // Control flag: error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else begin
      err_q <= err_d;
    end
  end

  // Next-state datapath
  always_comb begin
    d_d    = d_q;
    m_d    = m_q;
    y_d    = y_q;
    r400_d = r400_q;
    rem_d  = rem_q;
    err_d  = err_q;
    if (cmd_i.load) begin
      d_d   = start_day_i;
      m_d   = start_month_i;
      y_d   = start_year_i;
      rem_d = day_count_i[dobd_pkg::REM_W-1:0];
      err_d = 1'b0;
    end else if (cmd_i.rmod) begin
      r400_d = r400_full[8:0];
    end else if (cmd_i.chk) begin
      if ((m_q < dobd_pkg::MONTH_JAN) || (m_q > dobd_pkg::MONTH_DEC) ||
          (y_q > dobd_pkg::YEAR_MAX) || (d_q == 5'd0) || (d_q > dim)) begin
        err_d = 1'b1;
      end
    end else if (cmd_i.step && !finish) begin
      if (!sub_q) begin
        // forward: finish in this month or roll to the next
        if (rem_q <= dobd_pkg::REM_W'(left)) begin
          d_d   = d_q + rem_q[4:0];
          rem_d = '0;
        end else begin
          rem_d = rem_q - dobd_pkg::REM_W'({1'b0, left} + 6'd1);
          d_d   = 5'd1;
          if (m_q == dobd_pkg::MONTH_DEC) begin
            m_d = dobd_pkg::MONTH_JAN;
            if (y_q == dobd_pkg::YEAR_MAX) begin
              err_d = 1'b1;
              d_d   = d0_q;
              m_d   = m0_q;
              y_d   = y0_q;
            end else begin
              y_d    = y_q + 14'd1;
              r400_d = (r400_q == dobd_pkg::R400_LAST) ? 9'd0 : r400_q + 9'd1;
            end
          end else begin
            m_d = m_q + 4'd1;
          end
        end
      end else begin
        // backward: finish in this month or drop to the last day of the previous
        if (rem_q < dobd_pkg::REM_W'(d_q)) begin
          d_d   = d_q - rem_q[4:0];
          rem_d = '0;
        end else begin
          rem_d = rem_q - dobd_pkg::REM_W'(d_q);
          if (m_q == dobd_pkg::MONTH_JAN) begin
            m_d = dobd_pkg::MONTH_DEC;
            d_d = 5'd31;
            if (y_q == 14'd0) begin
              err_d = 1'b1;
              d_d   = d0_q;
              m_d   = m0_q;
              y_d   = y0_q;
            end else begin
              y_d    = y_q - 14'd1;
              r400_d = (r400_q == 9'd0) ? dobd_pkg::R400_LAST : r400_q - 9'd1;
            end
          end else begin
            m_d = m_q - 4'd1;
            d_d = prev_len;
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    d_q    <= d_d;
    m_q    <= m_d;
    y_q    <= y_d;
    r400_q <= r400_d;
    rem_q  <= rem_d;
    if (cmd_i.load) begin
      d0_q  <= start_day_i;
      m0_q  <= start_month_i;
      y0_q  <= start_year_i;
      sub_q <= operation_i;
    end
    if (cmd_i.mul) begin
      prod_q <= 27'(y_q) * 27'(dobd_pkg::RECIP_400);
    end
  end

  assign sts_o.finish   = finish;
  assign result_day_o   = d_q;
  assign result_month_o = m_q;
  assign result_year_o  = y_q;
  assign error_flag_o   = err_q;

endmodule
